// File: design/can_multi_frame_reassembler_assert.svh
// Assertion macros used by the reassembler datapath.
`ifndef CAN_MULTI_FRAME_REASSEMBLER_ASSERT_SVH
`define CAN_MULTI_FRAME_REASSEMBLER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CMFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CMFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/cmfr_pkg.sv
// Types, constants and helper functions of the CAN multi-frame reassembler.
package cmfr_pkg;

    localparam int NODES       = 16;
    localparam int MAX_MSG_LEN = 48;
    localparam int FIRST_BYTES = 6;
    localparam int NEXT_BYTES  = 7;

    localparam int NODE_W      = $clog2(NODES);
    localparam int STORE_DEPTH = NODES * MAX_MSG_LEN;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int MAX_FRAMES  = 1 + (MAX_MSG_LEN - FIRST_BYTES + NEXT_BYTES - 1) / NEXT_BYTES;

    // Data byte offsets of the payload in a first frame and in later frames
    localparam logic [2:0] FIRST_OFS = 3'd2;
    localparam logic [2:0] NEXT_OFS  = 3'd1;

    localparam logic [2:0] SEQ_NONE  = 3'd0;
    localparam logic [2:0] SEQ_FIRST = 3'd1;
    localparam logic [2:0] SEQ_END   = 3'd7;

    localparam logic [7:0] CRC_POLY  = 8'h07;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_CRC    = 2'd1,
        STAT_COUNT  = 2'd2,
        STAT_LENGTH = 2'd3
    } status_t;

    typedef struct packed {
        logic [10:0] frame_id;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [7:0]  byte4;
        logic [7:0]  byte5;
        logic [7:0]  byte6;
        logic [7:0]  byte7;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  node_num;
        logic [3:0]  kind;
        logic [3:0]  target;
        logic [7:0]  payload_byte;
        logic [5:0]  byte_index;
        logic        last;
        logic [1:0]  status;
        logic [15:0] bad_total;
        logic [15:0] good_total;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_WRITE,
        S_CRC,
        S_CRC_WAIT,
        S_FINISH,
        S_MARKER,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch;
        logic decode;
        logic wr_step;
        logic crc_step;
        logic finish;
        logic out_marker;
        logic emit_rd;
        logic emit_load;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic ignore;
        logic msg_end;
        logic chk_crc;
        logic wr_last;
        logic crc_last_issue;
        logic fin_empty;
        logic emit_last;
        logic out_free;
    } dp_sts_t;

    // One byte of CRC-8, MSB first, on a value already xored with the data
    function automatic logic [7:0] crc8_byte(input logic [7:0] c_in);
        logic [7:0] c;
        c = c_in;
        for (int b = 0; b < 8; b++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Frames a message of the given length must span
    function automatic logic [3:0] need_frames(input logic [7:0] len);
        logic [3:0] n;
        n = 4'd1;
        for (int k = 0; k < MAX_FRAMES - 1; k++)
        begin
            if (len > 8'(FIRST_BYTES + NEXT_BYTES * k))
            begin
                n = n + 4'd1;
            end
        end
        return n;
    endfunction

endpackage

// File: design/cmfr_ctrl.sv
// Sequencing state machine of the reassembler.
module cmfr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  cmfr_pkg::dp_sts_t sts,
    output cmfr_pkg::dp_cmd_t cmd
);
    import cmfr_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = sts.ignore ? S_IDLE : S_WRITE;
            end
            S_WRITE:
            begin
                cmd.wr_step = 1'b1;
                if (sts.wr_last)
                begin
                    if (!sts.msg_end)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (sts.chk_crc)
                    begin
                        state_next = S_CRC;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_CRC:
            begin
                cmd.crc_step = 1'b1;
                if (sts.crc_last_issue)
                begin
                    state_next = S_CRC_WAIT;
                end
            end
            S_CRC_WAIT:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = sts.fin_empty ? S_MARKER : S_EMIT_RD;
            end
            S_MARKER:
            begin
                if (sts.out_free)
                begin
                    cmd.out_marker = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = sts.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/cmfr_datapath.sv
// Frame decode, per-node message store, CRC walk and result register.
`include "can_multi_frame_reassembler_assert.svh"

module cmfr_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               crc_en,
    input  cmfr_pkg::in_item_t in_data,
    input  cmfr_pkg::dp_cmd_t  cmd,
    output cmfr_pkg::dp_sts_t  sts,
    input  logic               out_stall,
    output logic               out_valid,
    output cmfr_pkg::out_item_t out_data
);
    import cmfr_pkg::*;

    // Frame and per-node state
    in_item_t          frame_reg;
    logic [NODE_W-1:0] node_reg;
    logic              node_ok_reg;
    logic [2:0]        fill_reg    [NODES];
    logic [7:0]        msg_len_reg [NODES];
    logic [7:0]        msg_hdr_reg [NODES];
    logic [7:0]        store_mem   [STORE_DEPTH];
    logic [7:0]        mem_q_reg;

    // Message registers
    logic [7:0]  len_reg;
    logic [7:0]  hdr_reg;
    status_t     status_reg;
    logic        end_reg;
    logic [7:0]  wbase_reg;
    logic        wfirst_reg;
    logic [2:0]  widx_reg;
    logic [7:0]  rd_idx_reg;
    logic        rd_vld_reg;
    logic [7:0]  rd_pos_reg;
    logic [7:0]  crc_reg;
    logic        crc_bad_reg;
    logic [7:0]  pay_len_reg;
    logic [15:0] bad_reg;
    logic [15:0] good_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;

    // Decode of the latched frame
    logic [2:0] seq;
    logic [7:0] hdr_in;
    logic [2:0] fill;
    logic [2:0] fill_eff;
    logic [3:0] new_fill;
    logic       is_single;
    logic       appends;
    logic       dec_ignore;
    logic [7:0] dec_len;
    logic [7:0] dec_hdr;
    status_t    dec_status;
    logic [7:0] dec_wbase;
    logic [7:0] fb [8];

    assign fb[0] = frame_reg.byte0;
    assign fb[1] = frame_reg.byte1;
    assign fb[2] = frame_reg.byte2;
    assign fb[3] = frame_reg.byte3;
    assign fb[4] = frame_reg.byte4;
    assign fb[5] = frame_reg.byte5;
    assign fb[6] = frame_reg.byte6;
    assign fb[7] = frame_reg.byte7;

    always_comb
    begin
        seq       = frame_reg.frame_id[2:0];
        hdr_in    = frame_reg.frame_id[10:3];
        fill      = fill_reg[node_reg];
        is_single = (seq == SEQ_END) && (fill == 3'd0);
        fill_eff  = (seq == SEQ_FIRST) ? 3'd0 : fill;
        appends   = (seq != SEQ_NONE) && (((seq - 3'd1) == fill_eff) || (seq == SEQ_END));
        new_fill  = {1'b0, fill_eff} + 4'd1;
        dec_ignore = !node_ok_reg || (!is_single && !appends);
        dec_len   = is_single ? frame_reg.byte1 : msg_len_reg[node_reg];
        dec_hdr   = is_single ? hdr_in : msg_hdr_reg[node_reg];
        if (is_single)
        begin
            if ((dec_len > 8'(FIRST_BYTES)) || (crc_en && (dec_len == 8'd0)))
            begin
                dec_status = STAT_LENGTH;
            end
            else
            begin
                dec_status = STAT_OK;
            end
        end
        else if ((dec_len > 8'(MAX_MSG_LEN)) || (crc_en && (dec_len == 8'd0)))
        begin
            dec_status = STAT_LENGTH;
        end
        else if (need_frames(dec_len) != new_fill)
        begin
            dec_status = STAT_COUNT;
        end
        else
        begin
            dec_status = STAT_OK;
        end
        if (is_single || (fill_eff == 3'd0))
        begin
            dec_wbase = 8'd0;
        end
        else
        begin
            dec_wbase = 8'(FIRST_BYTES) + 8'(NEXT_BYTES) * 8'(fill_eff - 3'd1);
        end
    end

    // Store addressing
    logic [ADDR_W-1:0] node_base;
    logic [7:0]        wpos;
    logic [2:0]        wsel;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;

    assign node_base = ADDR_W'(node_reg) * ADDR_W'(MAX_MSG_LEN);
    assign wpos      = wbase_reg + 8'(widx_reg);
    assign wsel      = widx_reg + (wfirst_reg ? FIRST_OFS : NEXT_OFS);
    assign wr_en     = cmd.wr_step && (wpos < 8'(MAX_MSG_LEN));
    assign rd_en     = cmd.crc_step || cmd.emit_rd;
    assign waddr     = node_base + ADDR_W'(wpos);
    assign raddr     = node_base + ADDR_W'(rd_idx_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[waddr] <= fb[wsel];
        end
        if (rd_en)
        begin
            mem_q_reg <= store_mem[raddr];
        end
    end

    // Finish decisions
    status_t    fin_status;
    logic [7:0] p_next;

    assign fin_status = ((status_reg == STAT_OK) && crc_en && crc_bad_reg) ? STAT_CRC
                                                                          : status_reg;
    assign p_next     = crc_en ? (len_reg - 8'd1) : len_reg;

    // Frame latch and per-node tables (length and header not reset)
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            frame_reg   <= in_data;
            node_reg    <= in_data.byte0[NODE_W-1:0];
            node_ok_reg <= ({1'b0, in_data.byte0} < 9'(NODES));
        end
        if (cmd.decode && !dec_ignore && !is_single && (fill_eff == 3'd0))
        begin
            msg_len_reg[node_reg] <= frame_reg.byte1;
            msg_hdr_reg[node_reg] <= hdr_in;
        end
        if (cmd.decode)
        begin
            len_reg    <= dec_len;
            hdr_reg    <= dec_hdr;
            end_reg    <= (seq == SEQ_END);
            wbase_reg  <= dec_wbase;
            wfirst_reg <= is_single || (fill_eff == 3'd0);
        end
        if (cmd.finish)
        begin
            pay_len_reg <= p_next;
        end
    end

    // Fill counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < NODES; n++)
            begin
                fill_reg[n] <= 3'd0;
            end
        end
        else if (cmd.decode && !dec_ignore && !is_single)
        begin
            fill_reg[node_reg] <= (seq == SEQ_END) ? 3'd0 : new_fill[2:0];
        end
    end

    // Sequencing counters, CRC walk and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg  <= STAT_OK;
            widx_reg    <= 3'd0;
            rd_idx_reg  <= 8'd0;
            rd_vld_reg  <= 1'b0;
            rd_pos_reg  <= 8'd0;
            crc_reg     <= 8'd0;
            crc_bad_reg <= 1'b0;
            bad_reg     <= 16'd0;
            good_reg    <= 16'd0;
        end
        else
        begin
            rd_vld_reg <= cmd.crc_step;
            rd_pos_reg <= rd_idx_reg;
            if (cmd.decode)
            begin
                status_reg  <= dec_status;
                widx_reg    <= 3'd0;
                rd_idx_reg  <= 8'd0;
                crc_reg     <= 8'd0;
                crc_bad_reg <= 1'b0;
            end
            if (cmd.wr_step)
            begin
                widx_reg <= widx_reg + 3'd1;
            end
            if (cmd.crc_step || cmd.emit_load)
            begin
                rd_idx_reg <= rd_idx_reg + 8'd1;
            end
            // The byte at the last position is the received CRC
            if (rd_vld_reg)
            begin
                if (rd_pos_reg == (len_reg - 8'd1))
                begin
                    crc_bad_reg <= (crc_reg != mem_q_reg);
                end
                else
                begin
                    crc_reg <= crc8_byte(crc_reg ^ mem_q_reg);
                end
            end
            if (cmd.finish)
            begin
                status_reg <= fin_status;
                rd_idx_reg <= 8'd0;
                if (fin_status != STAT_OK)
                begin
                    if (bad_reg != 16'hFFFF)
                    begin
                        bad_reg <= bad_reg + 16'd1;
                    end
                end
                else if (good_reg != 16'hFFFF)
                begin
                    good_reg <= good_reg + 16'd1;
                end
            end
        end
    end

    // Result register
    logic emit_last;
    logic out_free;

    assign emit_last = ((rd_idx_reg + 8'd1) == pay_len_reg);
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load || cmd.out_marker)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load || cmd.out_marker)
        begin
            out_reg.node_num   <= 4'(node_reg);
            out_reg.kind       <= hdr_reg[7:4];
            out_reg.target     <= hdr_reg[3:0];
            out_reg.bad_total  <= bad_reg;
            out_reg.good_total <= good_reg;
            if (cmd.emit_load)
            begin
                out_reg.payload_byte <= mem_q_reg;
                out_reg.byte_index   <= 6'(rd_idx_reg);
                out_reg.last         <= emit_last;
                out_reg.status       <= STAT_OK;
            end
            else
            begin
                out_reg.payload_byte <= 8'd0;
                out_reg.byte_index   <= 6'd0;
                out_reg.last         <= 1'b1;
                out_reg.status       <= status_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign sts.ignore         = dec_ignore;
    assign sts.msg_end        = end_reg;
    assign sts.chk_crc        = end_reg && (status_reg == STAT_OK) && crc_en;
    assign sts.wr_last        = (widx_reg == (wfirst_reg ? 3'(FIRST_BYTES - 1)
                                                         : 3'(NEXT_BYTES - 1)));
    assign sts.crc_last_issue = (rd_idx_reg == (len_reg - 8'd1));
    assign sts.fin_empty      = (fin_status != STAT_OK) || (p_next == 8'd0);
    assign sts.emit_last      = emit_last;
    assign sts.out_free       = out_free;

    // Checks
    `CMFR_ASSERT_NOW(a_load_free, cmd.emit_load || cmd.out_marker, out_free,
        "result loaded over a waiting result")
    `CMFR_ASSERT_NOW(a_crc_in_range, cmd.crc_step, rd_idx_reg < len_reg,
        "CRC walk read past the message")
    `CMFR_ASSERT_NEXT(a_finish_counts, cmd.finish,
        (bad_reg != $past(bad_reg)) || (good_reg != $past(good_reg))
        || ($past(bad_reg) == 16'hFFFF) || ($past(good_reg) == 16'hFFFF),
        "finished message not counted")

endmodule

// File: design/can_multi_frame_reassembler.sv
// CAN multi-frame reassembler top level: register port, controller and datapath.
//
// Collects CAN frames per sender node (data byte 0) into messages and, on the
// end frame, checks length, frame count and optionally a trailing CRC-8, then
// delivers one item per payload byte, or a single status item for an error or
// an empty payload. One frame is taken at a time: for a frame that does not end
// a message the block latches it, decodes it and, unless it is ignored, writes
// its data bytes to the store one at a time, the store having one write port.
// An end frame is then followed by the CRC walk when enabled (one stored byte
// read per cycle), a finish step that settles the status and, per payload byte
// delivered, a store read, then the result register, which waits on out_stall.
// Register 0 at address 0, bit 0: crc_check_enable, reset 1.
module can_multi_frame_reassembler (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  cmfr_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output cmfr_pkg::out_item_t out_data
);
    import cmfr_pkg::*;

    logic     crc_en_reg;
    dp_cmd_t  cmd;
    dp_sts_t  sts;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_en_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && pready && !paddr[2])
        begin
            crc_en_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {31'd0, crc_en_reg};

    cmfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    cmfr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .crc_en    (crc_en_reg),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// File: tb/tb.sv
// Self-checking testbench of the CAN multi-frame reassembler.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cmfr_pkg::*;

    typedef logic [7:0] msg_buf_t [MAX_MSG_LEN];

    localparam int CYCLE_LIMIT = 1500000;
    localparam int HOLD_CYCLES = 3000;
    localparam int SETTLE      = 200;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;

    // Shadow of the block state
    logic [2:0]  frames_held [NODES];
    logic [7:0]  held_len [NODES];
    logic [7:0]  held_hdr [NODES];
    msg_buf_t    held_bytes [NODES];
    logic [15:0] rejected_cnt;
    logic [15:0] accepted_cnt;
    logic        crc_on;

    out_item_t   pending_results [$];
    int          mismatches;
    int          sender_idle;
    int          receiver_idle;
    logic        hold_go;
    int          hold_count;
    int          cycle_count;
    int          frames_sent;

    localparam logic [2:0] REG_CRC_EN = 3'd0;

    can_multi_frame_reassembler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // CRC-8, polynomial 0x07, init 0, MSB first
    function automatic logic [7:0] crc8_of(msg_buf_t b, int n);
        logic [7:0] c;
        c = 8'h00;
        for (int i = 0; i < n; i++)
        begin
            c = c ^ b[i];
            for (int k = 0; k < 8; k++)
            begin
                c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
            end
        end
        return c;
    endfunction

    // Queue the results of one completed message
    function automatic void complete_message(int node, logic [7:0] hdr, msg_buf_t b,
                                             int len, status_t st_in);
        status_t   st;
        out_item_t r;
        int        nbytes;
        st = st_in;
        if (st == STAT_OK && crc_on && crc8_of(b, len - 1) != b[len - 1])
        begin
            st = STAT_CRC;
        end
        r.node_num   = node[3:0];
        r.kind       = hdr[7:4];
        r.target     = hdr[3:0];
        r.payload_byte = 8'h00;
        r.byte_index = 6'd0;
        r.last       = 1'b1;
        r.status     = st;
        if (st != STAT_OK)
        begin
            if (rejected_cnt != 16'hFFFF)
            begin
                rejected_cnt = rejected_cnt + 16'd1;
            end
            r.bad_total  = rejected_cnt;
            r.good_total = accepted_cnt;
            pending_results.push_back(r);
            return;
        end
        if (accepted_cnt != 16'hFFFF)
        begin
            accepted_cnt = accepted_cnt + 16'd1;
        end
        r.bad_total  = rejected_cnt;
        r.good_total = accepted_cnt;
        nbytes = crc_on ? len - 1 : len;
        if (nbytes == 0)
        begin
            pending_results.push_back(r);
            return;
        end
        for (int i = 0; i < nbytes; i++)
        begin
            r.payload_byte = b[i];
            r.byte_index   = i[5:0];
            r.last         = (i + 1 == nbytes);
            pending_results.push_back(r);
        end
    endfunction

    // Track one accepted frame and predict its results
    function automatic void predict_frame(in_item_t f);
        logic [7:0] d [8];
        int         seq;
        int         node;
        int         fill;
        int         len;
        int         need;
        int         base;
        logic [7:0] hdr;
        status_t    st;
        msg_buf_t   one;
        d[0] = f.byte0; d[1] = f.byte1; d[2] = f.byte2; d[3] = f.byte3;
        d[4] = f.byte4; d[5] = f.byte5; d[6] = f.byte6; d[7] = f.byte7;
        seq  = f.frame_id[2:0];
        hdr  = f.frame_id[10:3];
        node = f.byte0;
        if (node >= NODES)
        begin
            return;
        end
        fill = frames_held[node];
        // End frame with nothing held: message of one frame
        if (seq == SEQ_END && fill == 0)
        begin
            len = d[1];
            st  = STAT_OK;
            if (len > FIRST_BYTES || (crc_on && len == 0))
            begin
                st = STAT_LENGTH;
            end
            for (int i = 0; i < MAX_MSG_LEN; i++)
            begin
                one[i] = (i < FIRST_BYTES) ? d[2 + i] : 8'h00;
            end
            complete_message(node, hdr, one, len, st);
            return;
        end
        if (seq == SEQ_FIRST && fill != 0)
        begin
            fill = 0;
        end
        if (seq != SEQ_NONE && (seq - 1 == fill || seq == SEQ_END))
        begin
            if (fill == 0)
            begin
                held_len[node] = d[1];
                held_hdr[node] = hdr;
                for (int i = 0; i < FIRST_BYTES; i++)
                begin
                    held_bytes[node][i] = d[2 + i];
                end
            end
            else
            begin
                base = FIRST_BYTES + NEXT_BYTES * (fill - 1);
                for (int i = 0; i < NEXT_BYTES; i++)
                begin
                    if (base + i < MAX_MSG_LEN)
                    begin
                        held_bytes[node][base + i] = d[1 + i];
                    end
                end
            end
            fill++;
        end
        frames_held[node] = fill[2:0];
        if (seq == SEQ_END)
        begin
            frames_held[node] = 3'd0;
            len  = held_len[node];
            need = (len <= FIRST_BYTES) ? 1
                 : 1 + (len - FIRST_BYTES + NEXT_BYTES - 1) / NEXT_BYTES;
            st = STAT_OK;
            if (len > MAX_MSG_LEN || (crc_on && len == 0))
            begin
                st = STAT_LENGTH;
            end
            else if (need != fill)
            begin
                st = STAT_COUNT;
            end
            complete_message(node, held_hdr[node], held_bytes[node], len, st);
        end
    endfunction

    // Split a message into frames; skip_mid drops the first middle frame
    function automatic void build_message(int node, logic [3:0] kind, logic [3:0] tgt,
                                          int len, bit single, bit bad_crc, bit skip_mid,
                                          ref in_item_t fq [$]);
        msg_buf_t b;
        in_item_t f;
        int       need;
        int       pos;
        for (int i = 0; i < MAX_MSG_LEN; i++)
        begin
            b[i] = 8'($urandom);
        end
        if (crc_on && len >= 1 && len <= MAX_MSG_LEN)
        begin
            b[len - 1] = crc8_of(b, len - 1) ^ (bad_crc ? 8'($urandom_range(1, 255)) : 8'h00);
        end
        need = (len <= FIRST_BYTES) ? 1
             : 1 + (len - FIRST_BYTES + NEXT_BYTES - 1) / NEXT_BYTES;
        if (need > 7)
        begin
            need = 7;
        end
        f.frame_id = {kind, tgt, (single ? SEQ_END : SEQ_FIRST)};
        f.byte0 = 8'(node);
        f.byte1 = 8'(len);
        {f.byte2, f.byte3, f.byte4, f.byte5, f.byte6, f.byte7} =
            {b[0], b[1], b[2], b[3], b[4], b[5]};
        fq.push_back(f);
        if (single)
        begin
            return;
        end
        if (need == 1)
        begin
            need = 2;
        end
        for (int k = 1; k < need; k++)
        begin
            pos = FIRST_BYTES + NEXT_BYTES * (k - 1);
            f.frame_id = {kind, tgt, (k == need - 1) ? SEQ_END : 3'(k + 1)};
            f.byte0 = 8'(node);
            {f.byte1, f.byte2, f.byte3, f.byte4, f.byte5, f.byte6, f.byte7} =
                {b[(pos) % MAX_MSG_LEN], b[(pos + 1) % MAX_MSG_LEN],
                 b[(pos + 2) % MAX_MSG_LEN], b[(pos + 3) % MAX_MSG_LEN],
                 b[(pos + 4) % MAX_MSG_LEN], b[(pos + 5) % MAX_MSG_LEN],
                 b[(pos + 6) % MAX_MSG_LEN]};
            if (!(skip_mid && k == 1 && need > 2))
            begin
                fq.push_back(f);
            end
        end
    endfunction

    function automatic in_item_t noise_frame();
        in_item_t f;
        f = in_item_t'({$urandom, $urandom, $urandom});
        if ($urandom_range(0, 3) != 0)
        begin
            f.byte0 = 8'($urandom_range(0, NODES - 1));
        end
        return f;
    endfunction

    // Offer one frame and wait for it to be taken
    task automatic send_frame(in_item_t f);
        while ($urandom_range(0, 99) < sender_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= f;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_frame(f);
        frames_sent++;
    endtask

    task automatic send_all(ref in_item_t fq [$]);
        while (fq.size() > 0)
        begin
            send_frame(fq.pop_front());
        end
    endtask

    // Stop offering and wait until every expected result has come
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_results.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_crc_enable(logic en);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= REG_CRC_EN;
        pwdata  <= {31'd0, en};
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        crc_on = en;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $time);
        mismatches++;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report("unexpected item node", out_data.node_num, -1);
            end
            else
            begin
                e = pending_results.pop_front();
                if (out_data.node_num !== e.node_num)
                    report("node_num", out_data.node_num, e.node_num);
                if (out_data.kind !== e.kind)
                    report("kind", out_data.kind, e.kind);
                if (out_data.target !== e.target)
                    report("target", out_data.target, e.target);
                if (out_data.payload_byte !== e.payload_byte)
                    report("payload_byte", out_data.payload_byte, e.payload_byte);
                if (out_data.byte_index !== e.byte_index)
                    report("byte_index", out_data.byte_index, e.byte_index);
                if (out_data.last !== e.last)
                    report("last", out_data.last, e.last);
                if (out_data.status !== e.status)
                    report("status", out_data.status, e.status);
                if (out_data.bad_total !== e.bad_total)
                    report("bad_total", out_data.bad_total, e.bad_total);
                if (out_data.good_total !== e.good_total)
                    report("good_total", out_data.good_total, e.good_total);
            end
        end
    end

    // Receiver stall, with one long hold-off when requested
    initial
    begin
        out_stall  = 1'b1;
        hold_count = 0;
        forever
        begin
            @(posedge clk);
            if (hold_go && hold_count < HOLD_CYCLES)
            begin
                hold_count++;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < receiver_idle);
            end
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic test_single_frames();
        in_item_t fq [$];
        // empty length with CRC is a length error; length 1 is an empty payload
        build_message(0, 4'h0, 4'h0, 0, 1, 0, 0, fq);
        build_message(1, 4'hF, 4'hF, 1, 1, 0, 0, fq);
        build_message(2, 4'hA, 4'h5, 6, 1, 0, 0, fq);
        build_message(3, 4'h5, 4'hA, 6, 1, 1, 0, fq);
        build_message(4, 4'h1, 4'h2, 7, 1, 0, 0, fq);
        send_all(fq);
        drain();
    endtask

    task automatic test_multi_frames();
        in_item_t fq [$];
        in_item_t f;
        build_message(15, 4'hF, 4'h0, MAX_MSG_LEN, 0, 0, 0, fq);
        build_message(5, 4'h3, 4'hC, 20, 0, 1, 0, fq);
        build_message(6, 4'h7, 4'h7, 49, 0, 0, 0, fq);
        build_message(7, 4'h2, 4'h9, 30, 0, 0, 1, fq);
        build_message(8, 4'h9, 4'h1, 4, 0, 0, 0, fq);
        send_all(fq);
        // ignored frames: code zero, node out of range, out-of-order middle
        f = noise_frame(); f.frame_id[2:0] = SEQ_NONE; send_frame(f);
        f = noise_frame(); f.byte0 = 8'hFF; send_frame(f);
        f = noise_frame(); f.byte0 = 8'd16; f.frame_id[2:0] = SEQ_END; send_frame(f);
        build_message(9, 4'h4, 4'h4, 25, 0, 0, 0, fq);
        f = fq[2]; fq.delete(2); fq.insert(1, f);
        send_all(fq);
        // first frame restarts a partial message; end frame after a partial one
        build_message(10, 4'h6, 4'h6, 40, 0, 0, 0, fq);
        void'(fq.pop_back()); void'(fq.pop_back());
        send_all(fq);
        build_message(10, 4'h8, 4'h3, 13, 0, 0, 0, fq);
        send_all(fq);
        build_message(11, 4'hB, 4'hD, 40, 0, 0, 0, fq);
        fq = fq[0:1];
        f = fq[1]; f.frame_id[2:0] = SEQ_END; fq.push_back(f);
        send_all(fq);
        drain();
    endtask

    task automatic test_crc_disabled();
        in_item_t fq [$];
        write_crc_enable(1'b0);
        build_message(0, 4'h1, 4'h1, 0, 1, 0, 0, fq);
        build_message(1, 4'h2, 4'h2, 5, 1, 0, 0, fq);
        build_message(2, 4'h3, 4'h3, 33, 0, 0, 0, fq);
        send_all(fq);
        drain();
        write_crc_enable(1'b1);
    endtask

    // Two interleaved streams of messages plus noise
    task automatic random_traffic(int count);
        in_item_t lane_a [$];
        in_item_t lane_b [$];
        int       stop_at;
        int       len;
        bit       single;
        bit       bad_crc;
        bit       skip_mid;
        stop_at = frames_sent + count;
        while (frames_sent < stop_at)
        begin
            while (lane_a.size() == 0 || lane_b.size() == 0)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 55)
                                                  : $urandom_range(1, 20);
                single   = (len <= FIRST_BYTES) && ($urandom_range(0, 1) == 1);
                bad_crc  = ($urandom_range(0, 7) == 0);
                skip_mid = ($urandom_range(0, 9) == 0);
                if (lane_a.size() == 0)
                begin
                    build_message(2 * $urandom_range(0, 7), 4'($urandom), 4'($urandom),
                                  len, single, bad_crc, skip_mid, lane_a);
                end
                else
                begin
                    build_message(2 * $urandom_range(0, 7) + 1, 4'($urandom),
                                  4'($urandom), len, single, bad_crc, skip_mid, lane_b);
                end
            end
            if ($urandom_range(0, 9) == 0)
                send_frame(noise_frame());
            else if ($urandom_range(0, 1))
                send_frame(lane_a.pop_front());
            else
                send_frame(lane_b.pop_front());
        end
        send_all(lane_a);
        send_all(lane_b);
        drain();
    endtask

    // Receiver holds off while long messages keep coming
    task automatic test_backpressure();
        in_item_t fq [$];
        hold_go = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            build_message(i, 4'($urandom), 4'($urandom), MAX_MSG_LEN, 0, 0, 0, fq);
        end
        send_all(fq);
        drain();
    endtask

    initial
    begin
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        in_data  = '0;
        hold_go  = 1'b0;
        mismatches  = 0;
        frames_sent = 0;
        sender_idle   = 37;
        receiver_idle = 67;
        for (int i = 0; i < NODES; i++)
        begin
            frames_held[i] = 3'd0;
            held_len[i]    = 8'd0;
            held_hdr[i]    = 8'd0;
            for (int j = 0; j < MAX_MSG_LEN; j++)
            begin
                held_bytes[i][j] = 8'h00;
            end
        end
        rejected_cnt = 16'd0;
        accepted_cnt = 16'd0;
        crc_on       = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_frames();
        test_multi_frames();
        test_crc_disabled();
        random_traffic(130);

        sender_idle   = 67;
        receiver_idle = 37;
        write_crc_enable(1'b0);
        random_traffic(130);
        write_crc_enable(1'b1);
        test_backpressure();

        sender_idle   = 0;
        receiver_idle = 0;
        random_traffic(160);

        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
